// ----- sv/skt_pkg.sv -----
// Shared types and constants for the sorted key table.
`timescale 1ns / 1ps

package skt_pkg;

	localparam int KEY_W    = 10;
	localparam int CNT_W    = 16;
	localparam int STATUS_W = 2;
	localparam int POS_W    = 6;
	localparam int USED_W   = 7;

	localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] ST_DUP       = 2'd3;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_SEARCH = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PROBE,
		S_CMP,
		S_SHIFT,
		S_PLACE
	} state_t;

endpackage

// ----- sv/sorted_key_table.sv -----
// Sorted key table: insert with shift-down and binary search over one entry memory.
//
//   channel   signals                                    transfer
//   command   start, busy, kind, key, count_value        start & !busy
//   result    done, status, position, count_out,         done (one cycle)
//             entries_used
//
// Each binary-search probe is a memory read, then a compare. An insert searches
// the same way, then moves each larger entry down one place from the end and
// makes a final write of the new entry. The entry memory has one read port and
// one write port.
// Reset clears the state, the fill level and done; the memory holds no valid bits.
// The receiver cannot stall; a new command is taken in the cycle done is shown.
`timescale 1ns / 1ps

module sorted_key_table #(
	parameter int CAPACITY = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          kind,
	input  logic [skt_pkg::KEY_W-1:0]     key,
	input  logic [skt_pkg::CNT_W-1:0]     count_value,
	output logic                          done,
	output logic [skt_pkg::STATUS_W-1:0]  status,
	output logic [skt_pkg::POS_W-1:0]     position,
	output logic [skt_pkg::CNT_W-1:0]     count_out,
	output logic [skt_pkg::USED_W-1:0]    entries_used
);

	localparam int AW    = $clog2(CAPACITY);
	localparam int FW    = $clog2(CAPACITY + 1);
	localparam int ENT_W = skt_pkg::KEY_W + skt_pkg::CNT_W;

	skt_pkg::state_t state_q, state_n;

	logic [FW-1:0] fill_q, fill_n;
	logic          done_q, done_n;

	logic                         kind_q, kind_n;
	logic [skt_pkg::KEY_W-1:0]    key_q, key_n;
	logic [skt_pkg::CNT_W-1:0]    cnt_q, cnt_n;
	logic [FW-1:0]                lo_q, lo_n, hi_q, hi_n, mid_q, mid_n;
	logic [AW-1:0]                idx_q, idx_n;
	logic [skt_pkg::STATUS_W-1:0] status_q, status_n;
	logic [skt_pkg::POS_W-1:0]    pos_q, pos_n;
	logic [skt_pkg::CNT_W-1:0]    cout_q, cout_n;
	logic [skt_pkg::USED_W-1:0]   used_q, used_n;

	logic [ENT_W-1:0] mem [CAPACITY];
	logic [ENT_W-1:0] rd_q;
	logic             we, re;
	logic [AW-1:0]    waddr, raddr;
	logic [ENT_W-1:0] wdata;

	logic [skt_pkg::KEY_W-1:0] rd_key;
	logic [skt_pkg::CNT_W-1:0] rd_cnt;
	logic [FW-1:0]             mid;

	assign rd_key = rd_q[ENT_W-1 -: skt_pkg::KEY_W];
	assign rd_cnt = rd_q[skt_pkg::CNT_W-1:0];
	assign mid    = lo_q + ((hi_q - lo_q) >> 1);

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= skt_pkg::S_IDLE;
			fill_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			fill_q  <= fill_n;
			done_q  <= done_n;
		end
	end

	always_ff @(posedge clk) begin
		kind_q   <= kind_n;
		key_q    <= key_n;
		cnt_q    <= cnt_n;
		lo_q     <= lo_n;
		hi_q     <= hi_n;
		mid_q    <= mid_n;
		idx_q    <= idx_n;
		status_q <= status_n;
		pos_q    <= pos_n;
		cout_q   <= cout_n;
		used_q   <= used_n;
	end

	always_comb begin
		state_n  = state_q;
		fill_n   = fill_q;
		done_n   = 1'b0;
		kind_n   = kind_q;
		key_n    = key_q;
		cnt_n    = cnt_q;
		lo_n     = lo_q;
		hi_n     = hi_q;
		mid_n    = mid_q;
		idx_n    = idx_q;
		status_n = status_q;
		pos_n    = pos_q;
		cout_n   = cout_q;
		used_n   = used_q;
		we       = 1'b0;
		re       = 1'b0;
		waddr    = idx_q;
		raddr    = idx_q;
		wdata    = {key_q, cnt_q};

		case (state_q)
			skt_pkg::S_IDLE: begin
				if (start) begin
					kind_n  = kind;
					key_n   = key;
					cnt_n   = count_value;
					lo_n    = '0;
					hi_n    = fill_q;
					state_n = skt_pkg::S_PROBE;
				end
			end
			skt_pkg::S_PROBE: begin
				if (lo_q < hi_q) begin
					re      = 1'b1;
					raddr   = mid[AW-1:0];
					mid_n   = mid;
					state_n = skt_pkg::S_CMP;
				end else if (kind_q == skt_pkg::KIND_SEARCH) begin
					done_n   = 1'b1;
					status_n = skt_pkg::ST_NOT_FOUND;
					pos_n    = '0;
					cout_n   = '0;
					used_n   = skt_pkg::USED_W'(fill_q);
					state_n  = skt_pkg::S_IDLE;
				end else if (fill_q == FW'(CAPACITY)) begin
					done_n   = 1'b1;
					status_n = skt_pkg::ST_FULL;
					pos_n    = '0;
					cout_n   = '0;
					used_n   = skt_pkg::USED_W'(fill_q);
					state_n  = skt_pkg::S_IDLE;
				end else if (fill_q == '0) begin
					idx_n   = '0;
					state_n = skt_pkg::S_PLACE;
				end else begin
					re      = 1'b1;
					raddr   = AW'(fill_q - FW'(1));
					idx_n   = AW'(fill_q);
					state_n = skt_pkg::S_SHIFT;
				end
			end
			skt_pkg::S_CMP: begin
				if (rd_key == key_q) begin
					done_n  = 1'b1;
					used_n  = skt_pkg::USED_W'(fill_q);
					state_n = skt_pkg::S_IDLE;
					if (kind_q == skt_pkg::KIND_SEARCH) begin
						status_n = skt_pkg::ST_DONE;
						pos_n    = skt_pkg::POS_W'(mid_q);
						cout_n   = rd_cnt;
					end else begin
						status_n = skt_pkg::ST_DUP;
						pos_n    = '0;
						cout_n   = '0;
					end
				end else begin
					if (rd_key < key_q)
						lo_n = mid_q + FW'(1);
					else
						hi_n = mid_q;
					state_n = skt_pkg::S_PROBE;
				end
			end
			skt_pkg::S_SHIFT: begin
				we = 1'b1;
				if (rd_key > key_q) begin
					wdata = rd_q;
					idx_n = idx_q - AW'(1);
					if (idx_q != AW'(1)) begin
						re    = 1'b1;
						raddr = idx_q - AW'(2);
					end else begin
						state_n = skt_pkg::S_PLACE;
					end
				end else begin
					fill_n   = fill_q + FW'(1);
					done_n   = 1'b1;
					status_n = skt_pkg::ST_DONE;
					pos_n    = skt_pkg::POS_W'(idx_q);
					cout_n   = cnt_q;
					used_n   = skt_pkg::USED_W'(fill_q + FW'(1));
					state_n  = skt_pkg::S_IDLE;
				end
			end
			skt_pkg::S_PLACE: begin
				we       = 1'b1;
				fill_n   = fill_q + FW'(1);
				done_n   = 1'b1;
				status_n = skt_pkg::ST_DONE;
				pos_n    = skt_pkg::POS_W'(idx_q);
				cout_n   = cnt_q;
				used_n   = skt_pkg::USED_W'(fill_q + FW'(1));
				state_n  = skt_pkg::S_IDLE;
			end
			default: begin
				state_n = skt_pkg::S_IDLE;
			end
		endcase
	end

	assign busy         = (state_q != skt_pkg::S_IDLE);
	assign done         = done_q;
	assign status       = status_q;
	assign position     = pos_q;
	assign count_out    = cout_q;
	assign entries_used = used_q;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(CAPACITY))
		else $error("fill level above capacity");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == skt_pkg::S_IDLE)
		else $error("result shown while still working");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q != $past(fill_q) |-> done_q && status_q == skt_pkg::ST_DONE
			&& kind_q == skt_pkg::KIND_INSERT && fill_q == $past(fill_q) + FW'(1))
		else $error("fill level changed without an insert");

	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q) != skt_pkg::S_IDLE)
		else $error("result without a command");
`endif

endmodule
